[design/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, operation codes and status codes of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int IDX_IN_W   = 8;
  localparam int VALUE_W    = 32;
  localparam int RINDEX_W   = 6;
  localparam int RDATA_W    = 32;
  localparam int COUNT_W    = 7;

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_REMOVE = 2'd1;
  localparam func_t FN_GET    = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_RANGE  = 2'd2;
  localparam status_t ST_UNUSED = 2'd3;

  typedef struct packed {
    logic start;
    logic commit;
  } cmd_t;

endpackage

[design/spa_ctrl.sv]
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer of the slot pool allocator: takes one input beat, runs the commit
// step once the output register is free, and owns both handshakes.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  output spa_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r, in_rdy_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_comb begin
    cmd.start  = in_tvalid && in_rdy_r;
    cmd.commit = (state_r == S_COMMIT) && (!out_vld_r || out_tready);
  end

  always_comb begin
    state_nxt   = state_r;
    in_rdy_nxt  = in_rdy_r;
    out_vld_nxt = out_vld_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt  = S_COMMIT;
          in_rdy_nxt = 1'b0;
        end
      end
      S_COMMIT: begin
        if (cmd.commit) begin
          state_nxt   = S_IDLE;
          in_rdy_nxt  = 1'b1;
          out_vld_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt  = S_IDLE;
        in_rdy_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_rdy_r  <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_rdy_r  <= in_rdy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = in_rdy_r;
  assign out_tvalid = out_vld_r;

  a_start_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_COMMIT) && !in_rdy_r)
    else $error("accepted beat did not move the sequencer to commit");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_rdy_r == (state_r == S_IDLE))
    else $error("input ready disagrees with the sequencer state");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_vld_r)
    else $error("commit did not present a result beat");

endmodule

[design/spa_datapath.sv]
// ----------------------------------------------------------------------------
// spa_datapath
// Slot memories, link memories, free stack and used list registers of the
// slot pool allocator, with the result register.
// ----------------------------------------------------------------------------
module spa_datapath #(
  parameter int CAPACITY   = spa_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = spa_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spa_pkg::cmd_t                    cmd,
  input  spa_pkg::func_t                   in_func,
  input  logic [spa_pkg::IDX_IN_W-1:0]     in_slot_index,
  input  logic [spa_pkg::VALUE_W-1:0]      in_value,
  input  logic                             in_has_value,
  output spa_pkg::status_t                 out_status,
  output logic [spa_pkg::RINDEX_W-1:0]     out_result_index,
  output logic [spa_pkg::RDATA_W-1:0]      out_result_data,
  output logic [spa_pkg::COUNT_W-1:0]      out_used_count,
  output logic [spa_pkg::RINDEX_W-1:0]     out_first_used,
  output logic [spa_pkg::RINDEX_W-1:0]     out_last_used
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = '1;

  // Link memories and slot data.
  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
  logic [LW-1:0]         prev_mem [CAPACITY];
  logic [LW-1:0]         next_mem [CAPACITY];

  logic [CAPACITY-1:0] in_use_r, data_vld_r, prev_vld_r;
  logic [LW-1:0]       free_top_r, head_r, tail_r;
  logic [CW-1:0]       cnt_r;

  spa_pkg::func_t        op_r;
  spa_pkg::status_t      status_r;
  logic                  ok_r;
  logic [spa_pkg::IDX_IN_W-1:0] idx_r;
  logic [IW-1:0]         slot_r;
  logic                  has_r;
  logic [DATA_WIDTH-1:0] val_r;

  logic [DATA_WIDTH-1:0] data_rd_r;
  logic                  data_rd_vld_r;
  logic [LW-1:0]         prev_rd_r, next_rd_r;
  logic                  prev_rd_vld_r;

  logic [spa_pkg::RINDEX_W-1:0] rindex_r, first_r, last_r;
  logic [spa_pkg::RDATA_W-1:0]  rdata_r;
  logic [spa_pkg::COUNT_W-1:0]  count_r;
  spa_pkg::status_t             ostatus_r;

  // Accept step.
  logic [IW-1:0]          a_slot, rd_addr;
  logic                   a_range, a_used, a_ok;
  spa_pkg::status_t       a_status;
  logic [DATA_WIDTH+31:0] val_ext;

  assign a_slot  = in_slot_index[IW-1:0];
  assign a_range = {1'b0, in_slot_index} < (spa_pkg::IDX_IN_W+1)'(CAPACITY);
  assign a_used  = in_use_r[a_slot];
  assign rd_addr = (in_func == spa_pkg::FN_INSERT) ? free_top_r[IW-1:0] : a_slot;
  assign val_ext = {{DATA_WIDTH{1'b0}}, in_value};

  always_comb begin
    a_ok     = 1'b0;
    a_status = spa_pkg::ST_OK;
    unique case (in_func)
      spa_pkg::FN_INSERT: begin
        a_ok     = !free_top_r[LW-1];
        a_status = free_top_r[LW-1] ? spa_pkg::ST_FULL : spa_pkg::ST_OK;
      end
      spa_pkg::FN_REMOVE, spa_pkg::FN_GET: begin
        if (!a_range) begin
          a_status = spa_pkg::ST_RANGE;
        end else if (!a_used) begin
          a_status = spa_pkg::ST_UNUSED;
        end else begin
          a_ok = 1'b1;
        end
      end
      default: begin
        a_ok = 1'b0;
      end
    endcase
  end

  // Commit step.
  logic [LW-1:0]         slot_lw, p_val, p_rst;
  logic [LW:0]           slot_inc;
  logic [DATA_WIDTH-1:0] data_val;
  logic                  ins_ok, rem_ok;

  assign slot_lw  = {1'b0, slot_r};
  assign slot_inc = {2'b0, slot_r} + (LW+1)'(1);
  assign p_rst    = (slot_inc < (LW+1)'(CAPACITY)) ? slot_inc[LW-1:0] : NIL;
  assign p_val    = prev_rd_vld_r ? prev_rd_r : p_rst;
  assign data_val = data_rd_vld_r ? data_rd_r : '0;
  assign ins_ok   = ok_r && (op_r == spa_pkg::FN_INSERT);
  assign rem_ok   = ok_r && (op_r == spa_pkg::FN_REMOVE);

  logic [LW-1:0] free_top_nxt, head_nxt, tail_nxt;
  logic [CW-1:0] cnt_nxt;

  always_comb begin
    free_top_nxt = free_top_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    if (ins_ok) begin
      free_top_nxt = p_val;
      if (tail_r[LW-1]) begin
        head_nxt = slot_lw;
      end
      tail_nxt = slot_lw;
      cnt_nxt  = cnt_r + CW'(1);
    end else if (rem_ok) begin
      if (head_r == slot_lw) begin
        head_nxt = next_rd_r;
      end
      if (tail_r == slot_lw) begin
        tail_nxt = p_val;
      end
      free_top_nxt = slot_lw;
      cnt_nxt      = cnt_r - CW'(1);
    end
  end

  // One write port per memory; the prev and next ports are shared by the accept and commit steps.
  logic                  data_we, prev_we, next_we;
  logic [IW-1:0]         data_wa, prev_wa, next_wa;
  logic [DATA_WIDTH-1:0] data_wd;
  logic [LW-1:0]         prev_wd, next_wd;

  always_comb begin
    data_we = cmd.commit && ins_ok && has_r;
    data_wa = slot_r;
    data_wd = val_r;
    prev_we = 1'b0;
    prev_wa = slot_r;
    prev_wd = tail_r;
    next_we = 1'b0;
    next_wa = slot_r;
    next_wd = NIL;
    if (cmd.start) begin
      prev_we = (in_func == spa_pkg::FN_REMOVE) && a_ok;
      prev_wa = a_slot;
      prev_wd = free_top_r;
      next_we = (in_func == spa_pkg::FN_INSERT) && a_ok && !tail_r[LW-1];
      next_wa = tail_r[IW-1:0];
      next_wd = free_top_r;
    end else if (cmd.commit) begin
      if (ins_ok) begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end else if (rem_ok) begin
        prev_we = !next_rd_r[LW-1];
        prev_wa = next_rd_r[IW-1:0];
        prev_wd = p_val;
        next_we = !p_val[LW-1];
        next_wa = p_val[IW-1:0];
        next_wd = next_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      data_rd_r     <= data_mem[rd_addr];
      prev_rd_r     <= prev_mem[rd_addr];
      next_rd_r     <= next_mem[rd_addr];
      data_rd_vld_r <= data_vld_r[rd_addr];
      prev_rd_vld_r <= prev_vld_r[rd_addr];
    end
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= '0;
      data_vld_r <= '0;
      prev_vld_r <= '0;
      free_top_r <= '0;
      head_r     <= NIL;
      tail_r     <= NIL;
      cnt_r      <= '0;
    end else begin
      if (data_we) begin
        data_vld_r[data_wa] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld_r[prev_wa] <= 1'b1;
      end
      if (cmd.commit) begin
        free_top_r <= free_top_nxt;
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        cnt_r      <= cnt_nxt;
        if (ins_ok) begin
          in_use_r[slot_r] <= 1'b1;
        end else if (rem_ok) begin
          in_use_r[slot_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r     <= in_func;
      ok_r     <= a_ok;
      status_r <= a_status;
      idx_r    <= in_slot_index;
      slot_r   <= rd_addr;
      has_r    <= in_has_value;
      val_r    <= val_ext[DATA_WIDTH-1:0];
    end
  end

  // Result fields, cut or widened to the beat's field widths.
  logic [IW+spa_pkg::RINDEX_W-1:0]      slot_ext, head_ext, tail_ext;
  logic [DATA_WIDTH+spa_pkg::RDATA_W-1:0] rdata_ext;
  logic [CW+spa_pkg::COUNT_W-1:0]       cnt_ext;
  logic [DATA_WIDTH-1:0]                rdata_sel;
  logic                                 list_live;

  assign slot_ext  = {{spa_pkg::RINDEX_W{1'b0}}, slot_r};
  assign head_ext  = {{spa_pkg::RINDEX_W{1'b0}}, head_nxt[IW-1:0]};
  assign tail_ext  = {{spa_pkg::RINDEX_W{1'b0}}, tail_nxt[IW-1:0]};
  assign rdata_sel = (ok_r && (op_r == spa_pkg::FN_REMOVE || op_r == spa_pkg::FN_GET))
                     ? data_val : '0;
  assign rdata_ext = {{spa_pkg::RDATA_W{1'b0}}, rdata_sel};
  assign cnt_ext   = {{spa_pkg::COUNT_W{1'b0}}, cnt_nxt};
  assign list_live = (cnt_nxt != '0);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ostatus_r <= status_r;
      if (op_r == spa_pkg::FN_INSERT) begin
        rindex_r <= ok_r ? slot_ext[spa_pkg::RINDEX_W-1:0] : '0;
      end else begin
        rindex_r <= idx_r[spa_pkg::RINDEX_W-1:0];
      end
      rdata_r <= rdata_ext[spa_pkg::RDATA_W-1:0];
      count_r <= cnt_ext[spa_pkg::COUNT_W-1:0];
      first_r <= (list_live && !head_nxt[LW-1]) ? head_ext[spa_pkg::RINDEX_W-1:0] : '0;
      last_r  <= (list_live && !tail_nxt[LW-1]) ? tail_ext[spa_pkg::RINDEX_W-1:0] : '0;
    end
  end

  assign out_status       = ostatus_r;
  assign out_result_index = rindex_r;
  assign out_result_data  = rdata_r;
  assign out_used_count   = count_r;
  assign out_first_used   = first_r;
  assign out_last_used    = last_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == int'(cnt_r))
    else $error("live count disagrees with the used bits");

  a_head_null: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[LW-1] == (cnt_r == '0))
    else $error("used list head disagrees with the live count");

  a_tail_null: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r[LW-1] == (cnt_r == '0))
    else $error("used list tail disagrees with the live count");

endmodule

[design/slot_pool_allocator.sv]
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Fixed pool of slots with a free stack and a doubly linked used list.
// ----------------------------------------------------------------------------
// The input channel carries one command per beat: insert, remove or get,
// selected by in_tuser. Insert takes the top of the free stack (slots 0, 1,
// 2 in order after reset, then freed slots last-in first-out), appends it to
// the used list and may store a data word. Remove and get check the slot and
// return its data; remove also unlinks the slot and frees it. Each command
// gives exactly one result beat with a status, the slot, the data, the number
// of used slots and the head and tail of the used list.
// A command has an accept step and a commit step: the accept edge reads the
// link and data memories, the commit edge writes them back and loads the
// result register, and out_tvalid rises right after it. No new beat is taken
// until the command has committed, as the link memories are read and then
// written back in between. Reset clears the pool at once, with no clearing
// pass: per-slot valid bits give unwritten entries their reset contents. When
// the receiver stalls, the result waits in the output register; one more
// command is accepted and then holds in its commit step until that result is
// taken.
module slot_pool_allocator #(
  parameter int CAPACITY   = spa_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = spa_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // slot_index[7:0], value[39:8]
  input  logic [2:0]  in_tuser,   // func[1:0], has_value[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // result_index[5:0], result_data[37:6],
                                  // used_count[44:38], first_used[50:45],
                                  // last_used[56:51], zero[63:57]
  output logic [1:0]  out_tuser   // status[1:0]
);

  spa_pkg::cmd_t                cmd;
  logic [spa_pkg::RINDEX_W-1:0] result_index, first_used, last_used;
  logic [spa_pkg::RDATA_W-1:0]  result_data;
  logic [spa_pkg::COUNT_W-1:0]  used_count;
  spa_pkg::status_t             status;

  spa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spa_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_tuser[1:0]),
    .in_slot_index    (in_tdata[7:0]),
    .in_value         (in_tdata[39:8]),
    .in_has_value     (in_tuser[2]),
    .out_status       (status),
    .out_result_index (result_index),
    .out_result_data  (result_data),
    .out_used_count   (used_count),
    .out_first_used   (first_used),
    .out_last_used    (last_used)
  );

  assign out_tdata = {7'b0, last_used, first_used, used_count, result_data, result_index};
  assign out_tuser = status;

endmodule
